>>> rtl/core/bdr_pkg.sv
`default_nettype none

package bdr_pkg;

	localparam int DEPTH    = 64;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int OQ_DEPTH = 3;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_INS_FRONT = 2'd0,
		OP_INS_REAR  = 2'd1,
		OP_DEL_REAR  = 2'd2,
		OP_DISPLAY   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		status_t                  status;
		logic                     last;
	} res_t;

	typedef struct packed {
		logic                     we;
		logic [ADDR_W-1:0]        waddr;
		logic signed [DATA_W-1:0] wdata;
		logic                     re;
		logic [ADDR_W-1:0]        raddr;
	} mem_req_t;

	// ring slot of the entry at offset off from base, offset below DEPTH
	function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(DEPTH))
			sum = sum - (CNT_W+1)'(DEPTH);
		return sum[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/bdr_store.sv
`default_nettype none

module bdr_store
	import bdr_pkg::*;
(
	input  wire logic                     clk,
	input  wire mem_req_t                 req,
	output logic signed [DATA_W-1:0]      rdata
);

	logic signed [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
	end

	always_ff @(posedge clk) begin
		if (req.re)
			rdata <= mem[req.raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/bdr_ctrl.sv
`default_nettype none

module bdr_ctrl
	import bdr_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire func_t                    in_func,
	input  wire logic signed [DATA_W-1:0] in_value,
	input  wire logic [OQ_CNT_W-1:0]      oq_count,
	output mem_req_t                      mem_req,
	input  wire logic signed [DATA_W-1:0] mem_rdata,
	output logic                          push,
	output res_t                          push_beat
);

	typedef enum logic {S_IDLE, S_DISP} state_t;

	state_t             state_q;
	logic [ADDR_W-1:0]  head_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic               valid_s1;
	logic               from_mem_s1;
	status_t            status_s1;
	logic               last_s1;

	logic               credit;
	logic               accept;
	logic               full;
	logic               empty;
	logic [ADDR_W-1:0]  head_dec;
	logic               disp_step;
	logic               disp_last;

	// room in the output queue for every beat already in flight
	assign credit    = ((OQ_CNT_W+1)'(oq_count) + (OQ_CNT_W+1)'(valid_s1))
		< (OQ_CNT_W+1)'(OQ_DEPTH);
	assign in_ready  = (state_q == S_IDLE) && credit;
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_dec  = (head_q == '0) ? ADDR_W'(DEPTH - 1) : head_q - 1'b1;
	assign disp_step = (state_q == S_DISP) && credit;
	assign disp_last = (idx_q == count_q - 1'b1);

	always_comb begin
		mem_req       = '0;
		mem_req.wdata = in_value;
		if (accept) begin
			case (in_func)
				OP_INS_FRONT: begin
					mem_req.we    = !full;
					mem_req.waddr = head_dec;
				end
				OP_INS_REAR: begin
					mem_req.we    = !full;
					mem_req.waddr = slot(head_q, count_q);
				end
				OP_DEL_REAR: begin
					mem_req.re    = !empty;
					mem_req.raddr = slot(head_q, count_q - 1'b1);
				end
				default: begin
				end
			endcase
		end else if (disp_step) begin
			mem_req.re    = 1'b1;
			mem_req.raddr = slot(head_q, idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			from_mem_s1 <= 1'b0;
			status_s1   <= ST_OK;
			last_s1     <= 1'b0;
		end else begin
			valid_s1 <= 1'b0;
			if (accept) begin
				valid_s1    <= 1'b1;
				from_mem_s1 <= 1'b0;
				status_s1   <= ST_OK;
				last_s1     <= 1'b1;
				case (in_func)
					OP_INS_FRONT: begin
						if (full) begin
							status_s1 <= ST_FULL;
						end else begin
							head_q  <= head_dec;
							count_q <= count_q + 1'b1;
						end
					end
					OP_INS_REAR: begin
						if (full)
							status_s1 <= ST_FULL;
						else
							count_q <= count_q + 1'b1;
					end
					OP_DEL_REAR: begin
						if (empty) begin
							status_s1 <= ST_EMPTY;
						end else begin
							from_mem_s1 <= 1'b1;
							count_q     <= count_q - 1'b1;
							if (count_q == CNT_W'(1))
								head_q <= '0;
						end
					end
					default: begin
						if (empty) begin
							status_s1 <= ST_EMPTY;
						end else begin
							// display beats come from the streaming state
							valid_s1 <= 1'b0;
							idx_q    <= '0;
							state_q  <= S_DISP;
						end
					end
				endcase
			end else if (disp_step) begin
				valid_s1    <= 1'b1;
				from_mem_s1 <= 1'b1;
				status_s1   <= ST_OK;
				last_s1     <= disp_last;
				idx_q       <= idx_q + 1'b1;
				if (disp_last)
					state_q <= S_IDLE;
			end
		end
	end

	assign push             = valid_s1;
	assign push_beat.value  = from_mem_s1 ? mem_rdata : '0;
	assign push_beat.status = status_s1;
	assign push_beat.last   = last_s1;

endmodule

`default_nettype wire

>>> rtl/core/bounded_deque_ring.sv
// bounded deque of signed 32-bit values in a 64-entry ring memory, addressed by a
// head pointer and an entry count. s_tuser selects the operation (insert front,
// insert rear, delete rear, display) and s_tdata carries the value to insert.
// every operation answers with one beat (status ok, empty or full, tlast set),
// except display of a non-empty deque, which streams all entries front to rear
// with tlast on the final one. inserts and deletes can be accepted back to back
// while the output queue has room; a display holds s_tready low while it streams
// the stored entries, read one at a time through the single read port of the entry
// memory. results pass through a three-beat output queue, so input acceptance never
// depends on m_tready in the same cycle. no clearing pass runs after reset.
`default_nettype none

module bounded_deque_ring
	import bdr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value_in
	input  wire logic [1:0]  s_tuser,   // [1:0] func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] value_out
	output logic [1:0]       m_tuser,   // [1:0] status
	output logic             m_tlast
);

	mem_req_t                 mem_req;
	logic signed [DATA_W-1:0] mem_rdata;
	logic                     push;
	res_t                     push_beat;

	res_t                     oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]      wr_ptr_q;
	logic [OQ_PTR_W-1:0]      rd_ptr_q;
	logic [OQ_CNT_W-1:0]      oq_count_q;
	logic                     pop;
	res_t                     head_beat;

	bdr_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	bdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (func_t'(s_tuser)),
		.in_value  (s_tdata),
		.oq_count  (oq_count_q),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.push      (push),
		.push_beat (push_beat)
	);

	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (push)
			oq_q[wr_ptr_q] <= push_beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			oq_count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				oq_count_q <= oq_count_q + 1'b1;
			else if (pop && !push)
				oq_count_q <= oq_count_q - 1'b1;
		end
	end

	assign head_beat = oq_q[rd_ptr_q];
	assign m_tvalid  = (oq_count_q != '0);
	assign m_tdata   = head_beat.value;
	assign m_tuser   = head_beat.status;
	assign m_tlast   = head_beat.last;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import bdr_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 286;
	localparam int DRAIN_CYCLES = 16;

	typedef enum {RX_OPEN, RX_COIN, RX_QUARTER, RX_SPARSE} rx_mode_t;
	typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_t;

	// mirror of the deque contents; predicts the beats each accepted item produces
	class deque_mirror;
		logic [DATA_W-1:0] ring [DEPTH];
		int head_slot;
		int fill;
		int peak_fill;
		res_t pending_beats [$];
		int mismatches;
		int beats_seen;
		int n_insert, n_refused, n_delete, n_display, n_empty;

		function new();
			head_slot = 0;
			fill = 0;
			peak_fill = 0;
			mismatches = 0;
			beats_seen = 0;
			n_insert = 0;
			n_refused = 0;
			n_delete = 0;
			n_display = 0;
			n_empty = 0;
		endfunction

		function void push_beat(logic [DATA_W-1:0] v, status_t st, logic l);
			res_t r;
			r.value = v;
			r.status = st;
			r.last = l;
			pending_beats.push_back(r);
		endfunction

		function void note_accepted(func_t op, logic [DATA_W-1:0] val);
			int k;
			case (op)
				OP_INS_FRONT, OP_INS_REAR: begin
					n_insert++;
					if (fill >= DEPTH) begin
						n_refused++;
						push_beat('0, ST_FULL, 1'b1);
					end else begin
						if (op == OP_INS_FRONT) begin
							head_slot = (head_slot + DEPTH - 1) % DEPTH;
							ring[head_slot] = val;
						end else begin
							ring[(head_slot + fill) % DEPTH] = val;
						end
						fill++;
						if (fill > peak_fill)
							peak_fill = fill;
						push_beat('0, ST_OK, 1'b1);
					end
				end
				OP_DEL_REAR: begin
					n_delete++;
					if (fill == 0) begin
						n_empty++;
						push_beat('0, ST_EMPTY, 1'b1);
					end else begin
						push_beat(ring[(head_slot + fill - 1) % DEPTH], ST_OK, 1'b1);
						fill--;
						if (fill == 0)
							head_slot = 0;
					end
				end
				default: begin
					n_display++;
					if (fill == 0) begin
						n_empty++;
						push_beat('0, ST_EMPTY, 1'b1);
					end else begin
						for (k = 0; k < fill; k++)
							push_beat(ring[(head_slot + k) % DEPTH], ST_OK, k == fill - 1);
					end
				end
			endcase
		endfunction

		function void check_beat(logic [DATA_W-1:0] v, logic [1:0] st, logic l);
			res_t want;
			beats_seen++;
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("beat %0d unexpected: value %0d status %0d last %0b",
						beats_seen, $signed(v), st, l);
			end else begin
				want = pending_beats.pop_front();
				if (v !== want.value || st !== want.status || l !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat %0d: expected %0d st %0d last %0b, actual %0d st %0d last %0b",
							beats_seen, $signed(want.value), want.status, want.last,
							$signed(v), st, l);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] value_in
	logic [1:0]  s_tuser = '0;   // [1:0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // [31:0] value_out
	logic [1:0]  m_tuser;        // [1:0] status
	logic        m_tlast;

	deque_mirror mirror;
	int cycles = 0;
	int burst_left = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int rx_left = 0;
	int rx_tick = 0;

	bounded_deque_ring DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver backpressure: switches between stall patterns every so often
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 150);
			end else begin
				rx_left--;
			end
			rx_tick++;
			case (rx_mode)
				RX_OPEN:    m_tready <= 1'b1;
				RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
				RX_QUARTER: m_tready <= (rx_tick % 4) == 0;
				default:    m_tready <= $urandom_range(0, 3) != 0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			mirror.check_beat(m_tdata, m_tuser, m_tlast);
	end

	task automatic send_op(input func_t op, input logic [31:0] val);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= val;
		do @(posedge clk); while (!s_tready);
		mirror.note_accepted(op, val);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	function automatic func_t pick_op(input op_mix_t mix);
		int r;
		func_t ins;
		r = $urandom_range(0, 99);
		ins = $urandom_range(0, 1) ? OP_INS_REAR : OP_INS_FRONT;
		case (mix)
			MIX_GROW:   return (r < 80) ? ins : (r < 92) ? OP_DEL_REAR : OP_DISPLAY;
			MIX_SHRINK: return (r < 15) ? ins : (r < 90) ? OP_DEL_REAR : OP_DISPLAY;
			default:    return (r < 45) ? ins : (r < 87) ? OP_DEL_REAR : OP_DISPLAY;
		endcase
	endfunction

	initial begin
		int sent;
		int phase_len;
		op_mix_t mix;
		mirror = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty answers, extreme values, head wrap below slot zero
		send_op(OP_DISPLAY, 32'h1234_5678);
		send_op(OP_DEL_REAR, 32'hFFFF_FFFF);
		send_op(OP_INS_FRONT, 32'h7FFF_FFFF);
		send_op(OP_INS_FRONT, 32'h8000_0000);
		send_op(OP_INS_REAR, 32'h0000_0000);
		send_op(OP_INS_REAR, 32'hFFFF_FFFF);
		send_op(OP_INS_REAR, 32'h5555_5555);
		send_op(OP_INS_FRONT, 32'hAAAA_AAAA);
		send_op(OP_DISPLAY, 32'h0000_0000);
		send_op(OP_DEL_REAR, 32'h0000_0000);
		send_op(OP_DEL_REAR, 32'h7FFF_FFFF);
		send_op(OP_DISPLAY, 32'hFFFF_FFFF);
		repeat (4) send_op(OP_DEL_REAR, $urandom());
		send_op(OP_DEL_REAR, 32'h0000_0000);
		send_op(OP_DISPLAY, 32'h0000_0000);
		send_op(OP_INS_REAR, 32'h8000_0001);
		send_op(OP_DISPLAY, 32'h0000_0000);
		send_op(OP_DEL_REAR, 32'h0000_0000);
		send_op(OP_INS_FRONT, 32'hDEAD_BEEF);
		send_op(OP_DEL_REAR, 32'h0000_0000);

		// random: a long growth phase first so the full case is reached
		sent = 0;
		mix = MIX_GROW;
		phase_len = 110;
		while (sent < RANDOM_ITEMS) begin
			repeat (phase_len) begin
				if (sent < RANDOM_ITEMS) begin
					send_op(pick_op(mix), pick_value());
					sent++;
				end
			end
			mix = op_mix_t'($urandom_range(0, 2));
			phase_len = $urandom_range(15, 60);
		end

		s_tvalid <= 1'b0;
		while (mirror.pending_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ops: %0d inserts (%0d full), %0d deletes, %0d displays, %0d empty",
			mirror.n_insert, mirror.n_refused, mirror.n_delete, mirror.n_display, mirror.n_empty);
		$display("result beats checked: %0d, peak occupancy %0d of %0d, mismatches %0d",
			mirror.beats_seen, mirror.peak_fill, DEPTH, mirror.mismatches);
		if (mirror.mismatches == 0 && mirror.pending_beats.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/bdr_pkg.sv
rtl/core/bdr_store.sv
rtl/core/bdr_ctrl.sv
rtl/core/bounded_deque_ring.sv
tb/tb_top.sv
